// ===== src/bvft_pkg.sv =====
// Package for the block view frustum test: payload structs, decision codes,
// register indexes and the record passed from the classifier to the finisher.
// No dependencies.
package bvft_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 48;

  localparam int unsigned POS_W   = 24;  // Q15.8 position
  localparam int unsigned DELTA_W = 25;  // Q16.8 offset
  localparam int unsigned DSQ_W   = 52;  // squared distance, Q.16
  localparam int unsigned DOT_W   = 43;  // signed dot product, Q.22
  localparam int unsigned MAG_W   = 41;  // magnitude of a dot product
  localparam int unsigned RSQ_W   = 40;  // squared render distance

  typedef enum logic [2:0] {
    DEC_TOO_FAR    = 3'd0,
    DEC_NEAR       = 3'd1,
    DEC_BEHIND     = 3'd2,
    DEC_OUTSIDE_H  = 3'd3,
    DEC_OUTSIDE_V  = 3'd4,
    DEC_INSIDE     = 3'd5
  } decision_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CAMERA_X   = 4'd0,
    CFG_CAMERA_Y   = 4'd1,
    CFG_CAMERA_Z   = 4'd2,
    CFG_FORWARD    = 4'd3,
    CFG_RIGHT      = 4'd4,
    CFG_UP         = 4'd5,
    CFG_VIEW_RANGE = 4'd6,
    CFG_FOV_TAN    = 4'd7
  } cfg_index_t;

  typedef struct packed {
    logic signed [POS_W-1:0] block_z;
    logic signed [POS_W-1:0] block_y;
    logic signed [POS_W-1:0] block_x;
  } in_item_t;

  typedef struct packed {
    logic       visible;
    logic [2:0] decision;
  } out_item_t;

  // classified beat: early code, or pend set when the ratio tests decide
  typedef struct packed {
    decision_t          code;
    logic               pend;
    logic [DSQ_W-1:0]   dist_sq;
    logic [MAG_W-1:0]   depth;
    logic [MAG_W-1:0]   rmag;
    logic [MAG_W-1:0]   umag;
  } class_t;

endpackage

// ===== src/block_view_frustum_test_core.sv =====
// Top level of the block view frustum test: configuration registers and the
// front end, queue and back end. Depends on bvft_pkg, bvft_front, bvft_queue, bvft_back.

// Tests one block center per clock against the camera's view frustum. Beats
// are taken back to back, one per cycle, while the result side keeps up; a
// result passes 3 front stages, one queue slot, 26 square root stages at one
// result bit each, 8 divider stages for the angular margin, one product stage
// and the result register. The square root of the squared distance is the
// longest part of that path. The queue between the classifier and the
// finisher holds QUEUE_DEPTH beats, so a short stall on the result side does
// not reach the input at once. Configuration writes take effect immediately;
// the squared render distance is registered in the cycle after view_range is
// written, so write the registers while the block is idle.
module block_view_frustum_test_core #(
  parameter int unsigned QUEUE_DEPTH = bvft_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  bvft_pkg::in_item_t                  item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output bvft_pkg::out_item_t                 result,
  input  logic                                cfg_en,
  input  logic [bvft_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bvft_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bvft_pkg::*;

  // camera state
  logic signed [23:0] camera_x, camera_y, camera_z;
  logic [47:0]        forward_vector, right_vector, up_vector;
  logic [19:0]        view_range;
  logic [31:0]        fov_tangents;
  logic [RSQ_W-1:0]   range_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x       <= '0;
      camera_y       <= '0;
      camera_z       <= '0;
      forward_vector <= '0;
      right_vector   <= '0;
      up_vector      <= '0;
      view_range     <= '0;
      fov_tangents   <= '0;
    end else if (cfg_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_CAMERA_X:   camera_x       <= cfg_data[23:0];
        CFG_CAMERA_Y:   camera_y       <= cfg_data[23:0];
        CFG_CAMERA_Z:   camera_z       <= cfg_data[23:0];
        CFG_FORWARD:    forward_vector <= cfg_data[47:0];
        CFG_RIGHT:      right_vector   <= cfg_data[47:0];
        CFG_UP:         up_vector      <= cfg_data[47:0];
        CFG_VIEW_RANGE: view_range     <= cfg_data[19:0];
        CFG_FOV_TAN:    fov_tangents   <= cfg_data[31:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // range squared is registered from view_range, so it changes only after a config write or reset
  always_ff @(posedge clk) begin
    range_sq <= view_range * view_range;
  end

  logic   push, q_ready, q_valid, pop;
  class_t push_data, pop_data;

  // front: offset, squares, dots, far / near / behind classes
  bvft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cam_x      (camera_x),
    .cam_y      (camera_y),
    .cam_z      (camera_z),
    .fwd        (forward_vector),
    .rgt        (right_vector),
    .upv        (up_vector),
    .range_sq   (range_sq),
    .push       (push),
    .q_ready    (q_ready),
    .push_data  (push_data)
  );

  bvft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_ready   (q_ready),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data)
  );

  // back: distance root, margin, horizontal and vertical ratio tests
  bvft_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (pop_data),
    .pop          (pop),
    .tan_h        (fov_tangents[15:0]),
    .tan_v        (fov_tangents[31:16]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== src/bvft_front.sv =====
// Front end of the frustum test: offset, squares, dot products, early classes.
// Depends on bvft_pkg.
module bvft_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  bvft_pkg::in_item_t             item,
  input  logic signed [23:0]             cam_x,
  input  logic signed [23:0]             cam_y,
  input  logic signed [23:0]             cam_z,
  input  logic [47:0]                    fwd,
  input  logic [47:0]                    rgt,
  input  logic [47:0]                    upv,
  input  logic [bvft_pkg::RSQ_W-1:0]     range_sq,
  output logic                           push,
  input  logic                           q_ready,
  output bvft_pkg::class_t               push_data
);
  import bvft_pkg::*;

  logic en;
  logic v1, v2, v3;
  logic signed [DELTA_W-1:0] dx, dy, dz;
  logic [49:0] sqx, sqy, sqz;
  logic signed [40:0] pf [3];
  logic signed [40:0] pr [3];
  logic signed [40:0] pu [3];
  logic [DSQ_W-1:0] dist_sq;
  logic signed [DOT_W-1:0] dot_f, dot_r, dot_u;
  logic signed [DOT_W-1:0] abs_r, abs_u;
  logic signed [49:0] sx, sy, sz;

  assign en         = !v3 || q_ready;
  assign item_ready = en;
  assign push       = v3 && q_ready;

  assign sx = dx * dx;
  assign sy = dy * dy;
  assign sz = dz * dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DELTA_W'(item.block_x) - DELTA_W'(cam_x);
      dy <= DELTA_W'(item.block_y) - DELTA_W'(cam_y);
      dz <= DELTA_W'(item.block_z) - DELTA_W'(cam_z);
      sqx <= sx;
      sqy <= sy;
      sqz <= sz;
      pf[0] <= dx * $signed(fwd[15:0]);
      pf[1] <= dy * $signed(fwd[31:16]);
      pf[2] <= dz * $signed(fwd[47:32]);
      pr[0] <= dx * $signed(rgt[15:0]);
      pr[1] <= dy * $signed(rgt[31:16]);
      pr[2] <= dz * $signed(rgt[47:32]);
      pu[0] <= dx * $signed(upv[15:0]);
      pu[1] <= dy * $signed(upv[31:16]);
      pu[2] <= dz * $signed(upv[47:32]);
      dist_sq <= DSQ_W'(sqx) + DSQ_W'(sqy) + DSQ_W'(sqz);
      dot_f <= DOT_W'(pf[0]) + DOT_W'(pf[1]) + DOT_W'(pf[2]);
      dot_r <= DOT_W'(pr[0]) + DOT_W'(pr[1]) + DOT_W'(pr[2]);
      dot_u <= DOT_W'(pu[0]) + DOT_W'(pu[1]) + DOT_W'(pu[2]);
    end
  end

  always_comb begin
    abs_r = dot_r[DOT_W-1] ? -dot_r : dot_r;
    abs_u = dot_u[DOT_W-1] ? -dot_u : dot_u;
    push_data.dist_sq = dist_sq;
    push_data.depth   = MAG_W'(dot_f);
    push_data.rmag    = MAG_W'(abs_r);
    push_data.umag    = MAG_W'(abs_u);
    push_data.pend    = 1'b0;
    if (dist_sq > DSQ_W'(range_sq)) begin
      push_data.code = DEC_TOO_FAR;
    end else if (dist_sq < (DSQ_W'(225) << 16)) begin
      push_data.code = DEC_NEAR;
    end else if (dot_f <= 0) begin
      push_data.code = DEC_BEHIND;
    end else begin
      push_data.code = DEC_INSIDE;
      push_data.pend = 1'b1;
    end
  end

endmodule

// ===== src/bvft_queue.sv =====
// Short FIFO between front and back ends of the frustum test.
// Depends on bvft_pkg.
module bvft_queue #(
  parameter int unsigned DEPTH = bvft_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              q_ready,
  input  bvft_pkg::class_t  push_data,
  input  logic              pop,
  output logic              q_valid,
  output bvft_pkg::class_t  pop_data
);
  import bvft_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  class_t            mem [DEPTH];
  logic [PTR_W-1:0]  wr, rd;
  logic [CNT_W-1:0]  count;

  assign q_ready  = count != CNT_W'(DEPTH);
  assign q_valid  = count != '0;
  assign pop_data = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= (wr == LAST) ? '0 : wr + 1'b1;
      if (pop)  rd <= (rd == LAST) ? '0 : rd + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= push_data;
  end

endmodule

// ===== src/bvft_back.sv =====
// Back end of the frustum test: pipelined square root, margin divider,
// ratio products and the final decision register.
// Depends on bvft_pkg.
module bvft_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  bvft_pkg::class_t  q_data,
  output logic              pop,
  input  logic [15:0]       tan_h,
  input  logic [15:0]       tan_v,
  output logic              result_valid,
  input  logic              result_ready,
  output bvft_pkg::out_item_t result
);
  import bvft_pkg::*;

  localparam int unsigned SQ_STEPS = DSQ_W / 2;
  localparam int unsigned DV_STEPS = 8;
  localparam int unsigned S_W      = SQ_STEPS + 1;
  localparam int unsigned DV_W     = S_W + DV_STEPS - 1;
  localparam logic [DV_W-1:0] HALF_Q = DV_W'(524288);

  logic en;
  assign en  = !result_valid || result_ready;
  assign pop = q_valid && en;

  logic             sq_v  [SQ_STEPS];
  class_t           sq_sb [SQ_STEPS];
  logic [DSQ_W-1:0] sq_x  [SQ_STEPS];
  logic [DSQ_W-1:0] sq_r  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [DSQ_W-1:0] BIT = DSQ_W'(1) << (DSQ_W - 2 - 2 * k);
    logic             vi;
    class_t           sbi;
    logic [DSQ_W-1:0] xi, ri, trial;
    if (k == 0) begin : g_first
      assign vi  = q_valid;
      assign sbi = q_data;
      assign xi  = q_data.dist_sq;
      assign ri  = '0;
    end else begin : g_next
      assign vi  = sq_v[k-1];
      assign sbi = sq_sb[k-1];
      assign xi  = sq_x[k-1];
      assign ri  = sq_r[k-1];
    end
    assign trial = ri + BIT;
    always_ff @(posedge clk) begin
      if (rst) sq_v[k] <= 1'b0;
      else if (en) sq_v[k] <= vi;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_sb[k] <= sbi;
        if (xi >= trial) begin
          sq_x[k] <= xi - trial;
          sq_r[k] <= (ri >> 1) + BIT;
        end else begin
          sq_x[k] <= xi;
          sq_r[k] <= ri >> 1;
        end
      end
    end
  end

  // margin = round(2^19 / s), quotient fits 8 bits for s >= 3840
  logic              dv_v   [DV_STEPS];
  class_t            dv_sb  [DV_STEPS];
  logic [DV_W-1:0]   dv_rem [DV_STEPS];
  logic [S_W-1:0]    dv_s   [DV_STEPS];
  logic [DV_STEPS-1:0] dv_q [DV_STEPS];

  for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
    logic              vi;
    class_t            sbi;
    logic [DV_W-1:0]   remi, dsh;
    logic [S_W-1:0]    si;
    logic [DV_STEPS-1:0] qi;
    if (j == 0) begin : g_first
      assign vi   = sq_v[SQ_STEPS-1];
      assign sbi  = sq_sb[SQ_STEPS-1];
      assign si   = S_W'(sq_r[SQ_STEPS-1]);
      assign remi = HALF_Q + DV_W'(si >> 1);
      assign qi   = '0;
    end else begin : g_next
      assign vi   = dv_v[j-1];
      assign sbi  = dv_sb[j-1];
      assign si   = dv_s[j-1];
      assign remi = dv_rem[j-1];
      assign qi   = dv_q[j-1];
    end
    assign dsh = DV_W'(si) << (DV_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      if (rst) dv_v[j] <= 1'b0;
      else if (en) dv_v[j] <= vi;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_sb[j] <= sbi;
        dv_s[j]  <= si;
        if (remi >= dsh) begin
          dv_rem[j] <= remi - dsh;
          dv_q[j]   <= {qi[DV_STEPS-2:0], 1'b1};
        end else begin
          dv_rem[j] <= remi;
          dv_q[j]   <= {qi[DV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // limit * depth, depth split in two halves
  logic        m_v;
  class_t      m_sb;
  logic [37:0] ph_lo, pv_lo;
  logic [36:0] ph_hi, pv_hi;
  logic [16:0] lim_h, lim_v;
  class_t      dv_last;

  assign dv_last = dv_sb[DV_STEPS-1];
  assign lim_h   = 17'(tan_h) + 17'(dv_q[DV_STEPS-1]);
  assign lim_v   = 17'(tan_v) + 17'(dv_q[DV_STEPS-1]);

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= dv_v[DV_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_sb  <= dv_last;
      ph_lo <= lim_h * dv_last.depth[20:0];
      ph_hi <= lim_h * dv_last.depth[40:21];
      pv_lo <= lim_v * dv_last.depth[20:0];
      pv_hi <= lim_v * dv_last.depth[40:21];
    end
  end

  logic [57:0] prod_h, prod_v, rp, up;
  decision_t   code;

  always_comb begin
    prod_h = 58'(ph_lo) + (58'(ph_hi) << 21);
    prod_v = 58'(pv_lo) + (58'(pv_hi) << 21);
    rp     = 58'(m_sb.rmag) << 12;
    up     = 58'(m_sb.umag) << 12;
    if (!m_sb.pend)       code = m_sb.code;
    else if (rp > prod_h) code = DEC_OUTSIDE_H;
    else if (up > prod_v) code = DEC_OUTSIDE_V;
    else                  code = DEC_INSIDE;
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (en) result_valid <= m_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.decision <= code;
      result.visible  <= (code == DEC_NEAR) || (code == DEC_INSIDE);
    end
  end

endmodule
